/* rtl/mwf_pkg.sv */
// shared constants, state type and control structs of the median window filter
package mwf_pkg;

    localparam int WINDOW_DEF      = 5;
    localparam int SAMPLE_BITS_DEF = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic write;
        logic scan;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic last_issue;
    } t_stat;

endpackage

/* rtl/mwf_datapath.sv */
// window store, rank counting comparator and result registers
module mwf_datapath #(
    parameter int WINDOW      = mwf_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = mwf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mwf_pkg::t_cmd                 i_cmd,
    output mwf_pkg::t_stat                o_stat,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0] o_median
);
    import mwf_pkg::*;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW);

    logic signed [SAMPLE_BITS-1:0] mem [WINDOW];
    logic signed [SAMPLE_BITS-1:0] r_a, r_b, r_result, n_result, r_median;

    logic [IDX_W-1:0] r_wr_pos, n_wr_pos;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_i, n_i, r_j, n_j;
    logic [IDX_W-1:0] r_i_d, r_j_d;
    logic             r_pv;
    logic [CNT_W-1:0] r_rank, n_rank;

    logic [IDX_W-1:0] last;
    logic             less;
    logic [CNT_W-1:0] rank_next;

    assign last = IDX_W'(r_count - CNT_W'(1));
    assign o_stat.last_issue = (r_i == last) && (r_j == last);

    // window memory, one write and two registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            mem[r_wr_pos] <= i_sample;
        end
        r_a <= mem[r_i];
        r_b <= mem[r_j];
    end

    assign less      = (r_b < r_a) || ((r_b == r_a) && (r_j_d < r_i_d));
    assign rank_next = r_rank + CNT_W'(less);

    always_comb begin
        n_wr_pos = r_wr_pos;
        n_count  = r_count;
        n_i      = r_i;
        n_j      = r_j;
        n_rank   = r_rank;
        n_result = r_result;
        if (i_cmd.write) begin
            n_wr_pos = (r_wr_pos == LAST_POS) ? '0 : r_wr_pos + IDX_W'(1);
            if (r_count != FULL_CNT) begin
                n_count = r_count + CNT_W'(1);
            end
            n_i    = '0;
            n_j    = '0;
            n_rank = '0;
        end else if (i_cmd.scan && !o_stat.last_issue) begin
            if (r_j == last) begin
                n_j = '0;
                n_i = r_i + IDX_W'(1);
            end else begin
                n_j = r_j + IDX_W'(1);
            end
        end
        // rank of candidate i: entries below it, ties broken by index
        if (r_pv) begin
            if (r_j_d == last) begin
                n_rank = '0;
                if (rank_next == (r_count >> 1)) begin
                    n_result = r_a;
                end
            end else begin
                n_rank = rank_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos <= '0;
            r_count  <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_pv     <= 1'b0;
            r_rank   <= '0;
        end else begin
            r_wr_pos <= n_wr_pos;
            r_count  <= n_count;
            r_i      <= n_i;
            r_j      <= n_j;
            r_pv     <= i_cmd.scan;
            r_rank   <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i_d    <= r_i;
        r_j_d    <= r_j;
        r_result <= n_result;
        if (i_cmd.load_out) begin
            r_median <= r_result;
        end
    end

    assign o_median = r_median;

endmodule

/* rtl/mwf_ctrl.sv */
// controller state machine and output valid register
module mwf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    input  mwf_pkg::t_stat i_stat,
    output mwf_pkg::t_cmd  o_cmd
);
    import mwf_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall     = 1'b0;
                o_cmd.write = i_valid;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            ST_FINISH: begin
                o_cmd.load_out = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

/* rtl/median_window_filter.sv */
// Sliding-window median filter. Each input transfer writes one signed sample over the oldest
// entry of a WINDOW-deep ring; the result transfer carries the median of the entries written
// so far (the upper median while fewer than WINDOW samples have arrived and the count is even).
// A single comparator ranks each valid entry against every other, one pair per cycle from a
// two-read-port window memory. The finished median sits in an output register, so the next
// sample is taken while it waits; the input stalls for the rest of the ranking.
module median_window_filter #(
    parameter int WINDOW      = mwf_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = mwf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_median
);
    import mwf_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    mwf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    mwf_datapath #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .i_sample (i_sample),
        .o_median (o_median)
    );

`ifndef SYNTH
    // a transfer in starts the ranking, so the input stalls next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after sample transfer");

    a_load_shows_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> o_valid)
        else $error("result loaded but not presented");

    a_scan_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.scan && stat.last_issue) |=> !cmd.scan)
        else $error("ranking continues past last pair");

    a_write_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.write |-> (!o_stall && !cmd.scan && !cmd.load_out))
        else $error("window write outside idle");
`endif

endmodule
